@@ hdl/hrbp_pkg.sv @@
// Shared types and constant tables for the HTTP request byte parser.
// No dependencies; imported by hrbp_core and http_request_byte_parser_top.
package hrbp_pkg;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_URL     = 3'd1,
        PH_VERSION = 3'd2,
        PH_LINE    = 3'd3,
        PH_HEADER  = 3'd4,
        PH_BODY    = 3'd5,
        PH_END     = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        KIND_DROPPED = 3'd0,
        KIND_METHOD  = 3'd1,
        KIND_URL     = 3'd2,
        KIND_VERSION = 3'd3,
        KIND_NAME    = 3'd4,
        KIND_VALUE   = 3'd5,
        KIND_BODY    = 3'd6
    } t_kind;

    // Content-Length value scan: leading blanks, digits, finished, no digits
    typedef enum logic [1:0] {
        DG_LEAD   = 2'd0,
        DG_DIGITS = 2'd1,
        DG_DONE   = 2'd2,
        DG_NONE   = 2'd3
    } t_digits;

    localparam int          METH_COUNT = 9;
    localparam logic [7:0]  CH_CR      = 8'h0D;
    localparam logic [7:0]  CH_LF      = 8'h0A;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  CH_TAB     = 8'h09;
    localparam logic [7:0]  CH_COLON   = 8'h3A;
    localparam logic [3:0]  CL_LEN     = 4'd14;

    localparam logic [2:0] METH_LEN [METH_COUNT] = '{
        3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd7, 3'd7, 3'd5, 3'd5
    };

    localparam logic [7:0] METH_TEXT [METH_COUNT][8] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
        '{"C", "O", "N", "N", "E", "C", "T", 8'h00},
        '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
        '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00},
        '{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00}
    };

    // lower-case header name compared against
    localparam logic [7:0] CL_TEXT [14] = '{
        "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h"
    };

    typedef struct packed {
        t_phase      phase;
        logic [8:0]  method_match;
        logic [2:0]  method_len;
        logic [3:0]  name_pos;
        logic        name_matches;
        logic        in_value;
        logic        skip_next;
        t_digits     digits;
        logic        value_over;
        logic        length_seen;
        logic        length_bad;
    } t_ctl;

    typedef struct packed {
        t_kind       byte_kind;
        logic        field_end;
        logic [3:0]  method_code;
        logic        method_valid;
        logic        header_done;
        logic        request_done;
    } t_result;

endpackage

@@ hdl/hrbp_core.sv @@
// Next-state and result logic for one request byte of the parser.
// Depends on hrbp_pkg; instantiated by http_request_byte_parser_top.
module hrbp_core import hrbp_pkg::*; #(
    parameter int LENGTH_BITS = 24
) (
    input  t_ctl                   i_ctl,
    input  logic [LENGTH_BITS-1:0] i_value_accum,
    input  logic [LENGTH_BITS-1:0] i_length_value,
    input  logic [LENGTH_BITS-1:0] i_body_count,
    input  logic [LENGTH_BITS-1:0] i_cap,
    input  logic [7:0]             i_byte,
    input  logic                   i_start,
    output t_ctl                   o_ctl,
    output logic [LENGTH_BITS-1:0] o_value_accum,
    output logic [LENGTH_BITS-1:0] o_length_value,
    output logic [LENGTH_BITS-1:0] o_body_count,
    output t_result                o_res
);

    localparam int XW = LENGTH_BITS + 4;

    t_ctl                   s_ctl;
    logic [LENGTH_BITS-1:0] s_accum;
    logic [LENGTH_BITS-1:0] s_length;
    logic [LENGTH_BITS-1:0] s_body;
    logic [LENGTH_BITS-1:0] body_inc;
    logic                   do_header;
    logic                   is_digit;
    logic                   do_acc;
    logic [LENGTH_BITS-1:0] acc_base;
    logic [XW-1:0]          acc_next;
    logic [7:0]             lc;
    logic                   found;
    logic                   no_digits;

    // Start of request: clear everything before this byte is parsed
    always_comb begin
        if (i_start) begin
            s_ctl.phase        = PH_METHOD;
            s_ctl.method_match = '1;
            s_ctl.method_len   = '0;
            s_ctl.name_pos     = '0;
            s_ctl.name_matches = 1'b1;
            s_ctl.in_value     = 1'b0;
            s_ctl.skip_next    = 1'b0;
            s_ctl.digits       = DG_LEAD;
            s_ctl.value_over   = 1'b0;
            s_ctl.length_seen  = 1'b0;
            s_ctl.length_bad   = 1'b0;
            s_accum            = '0;
            s_length           = '0;
            s_body             = '0;
        end else begin
            s_ctl    = i_ctl;
            s_accum  = i_value_accum;
            s_length = i_length_value;
            s_body   = i_body_count;
        end
    end

    assign is_digit  = (i_byte >= "0") && (i_byte <= "9");
    assign acc_base  = (s_ctl.digits == DG_LEAD) ? '0 : s_accum;
    assign acc_next  = XW'({acc_base, 3'b000}) + XW'({acc_base, 1'b0})
                     + XW'(i_byte[3:0]);
    assign body_inc  = s_body + 1'b1;
    assign lc        = ((i_byte >= "A") && (i_byte <= "Z")) ? (i_byte + 8'd32) : i_byte;
    assign no_digits = (s_ctl.digits == DG_LEAD) || (s_ctl.digits == DG_NONE);

    always_comb begin
        o_ctl          = s_ctl;
        o_value_accum  = s_accum;
        o_length_value = s_length;
        o_body_count   = s_body;
        o_res          = '0;
        o_res.byte_kind = KIND_DROPPED;
        do_header      = 1'b0;
        do_acc         = 1'b0;
        found          = 1'b0;

        case (s_ctl.phase)
            PH_METHOD: begin
                if (i_byte == CH_SPACE) begin
                    for (int m = 0; m < METH_COUNT; m++) begin
                        if (!found && s_ctl.method_match[m]
                                && (METH_LEN[m] == s_ctl.method_len)) begin
                            found             = 1'b1;
                            o_res.method_code = 4'(m + 1);
                        end
                    end
                    o_res.method_valid = 1'b1;
                    o_res.field_end    = 1'b1;
                    o_ctl.phase        = PH_URL;
                end else if (i_byte != CH_CR) begin
                    o_res.byte_kind = KIND_METHOD;
                    for (int m = 0; m < METH_COUNT; m++) begin
                        if ((s_ctl.method_len >= METH_LEN[m])
                                || (METH_TEXT[m][s_ctl.method_len] != i_byte)) begin
                            o_ctl.method_match[m] = 1'b0;
                        end
                    end
                    if (s_ctl.method_len < 3'd7) begin
                        o_ctl.method_len = s_ctl.method_len + 1'b1;
                    end
                end
            end
            PH_URL: begin
                if (i_byte == CH_SPACE) begin
                    o_res.field_end = 1'b1;
                    o_ctl.phase     = PH_VERSION;
                end else if (i_byte != CH_CR) begin
                    o_res.byte_kind = KIND_URL;
                end
            end
            PH_VERSION: begin
                if (i_byte == CH_LF) begin
                    o_res.field_end = 1'b1;
                    o_ctl.phase     = PH_LINE;
                end else if (i_byte != CH_CR) begin
                    o_res.byte_kind = KIND_VERSION;
                end
            end
            PH_LINE: begin
                if (i_byte == CH_LF) begin
                    o_res.header_done = 1'b1;
                    if (s_ctl.length_seen && (s_length != '0)) begin
                        o_ctl.phase  = PH_BODY;
                        o_body_count = '0;
                    end else begin
                        o_ctl.phase        = PH_END;
                        o_res.request_done = 1'b1;
                    end
                end else if (i_byte != CH_CR) begin
                    do_header = 1'b1;
                end
            end
            PH_HEADER: begin
                do_header = 1'b1;
            end
            PH_BODY: begin
                o_res.byte_kind = KIND_BODY;
                o_body_count    = body_inc;
                if (body_inc >= s_length) begin
                    o_res.field_end    = 1'b1;
                    o_res.request_done = 1'b1;
                    o_ctl.phase        = PH_END;
                end
            end
            default: begin
                o_ctl.phase = PH_END;
            end
        endcase

        if (do_header) begin
            o_ctl.phase = PH_HEADER;
            if (i_byte == CH_LF) begin
                o_res.field_end = 1'b1;
                if (s_ctl.name_matches && (s_ctl.name_pos == CL_LEN)) begin
                    o_ctl.length_seen = 1'b1;
                    o_length_value    = no_digits ? '0 : s_accum;
                    o_ctl.length_bad  = no_digits || s_ctl.value_over;
                end
                // clear line state
                o_ctl.name_pos     = '0;
                o_ctl.name_matches = 1'b1;
                o_ctl.in_value     = 1'b0;
                o_ctl.skip_next    = 1'b0;
                o_ctl.digits       = DG_LEAD;
                o_ctl.value_over   = 1'b0;
                o_value_accum      = '0;
                o_ctl.phase        = PH_LINE;
            end else if (s_ctl.skip_next) begin
                o_ctl.skip_next = 1'b0;
            end else if (i_byte == CH_CR) begin
                o_ctl.phase = PH_HEADER;
            end else if (!s_ctl.in_value) begin
                if (i_byte == CH_COLON) begin
                    o_ctl.in_value  = 1'b1;
                    o_ctl.skip_next = 1'b1;
                    o_res.field_end = 1'b1;
                end else begin
                    o_res.byte_kind = KIND_NAME;
                    if ((s_ctl.name_pos < CL_LEN) && (lc == CL_TEXT[s_ctl.name_pos])) begin
                        o_ctl.name_pos = s_ctl.name_pos + 1'b1;
                    end else begin
                        o_ctl.name_matches = 1'b0;
                    end
                end
            end else begin
                o_res.byte_kind = KIND_VALUE;
                case (s_ctl.digits)
                    DG_LEAD: begin
                        if ((i_byte != CH_SPACE) && (i_byte != CH_TAB)) begin
                            if (is_digit) begin
                                o_ctl.digits = DG_DIGITS;
                                do_acc       = 1'b1;
                            end else begin
                                o_ctl.digits = DG_NONE;
                            end
                        end
                    end
                    DG_DIGITS: begin
                        if (is_digit) begin
                            do_acc = 1'b1;
                        end else begin
                            o_ctl.digits = DG_DONE;
                        end
                    end
                    default: begin
                        o_ctl.digits = s_ctl.digits;
                    end
                endcase
                if (do_acc) begin
                    if (acc_next > XW'(i_cap)) begin
                        o_value_accum    = i_cap;
                        o_ctl.value_over = 1'b1;
                    end else begin
                        o_value_accum = LENGTH_BITS'(acc_next);
                    end
                end
            end
        end
    end

endmodule

@@ hdl/http_request_byte_parser_top.sv @@
// Top level of the HTTP/1.1 request byte parser: handshakes, registers, output stage.
// Depends on hrbp_pkg and hrbp_core.
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ------------------------------------
//  s        in         i_s_tvalid / o_s_tready   tdata: byte_in; tuser: start_req
//  m        out        o_m_tvalid / i_m_tready   tdata: byte, flags, length; tuser: kind;
//                                                tlast: request_done
//  cfg      in         i_cfg_valid / o_cfg_ready i_cfg_data: max_body_bytes
//
// One item in, one item out. Each accepted byte is parsed in the cycle it is
// accepted and its result appears on the m channel in the next cycle; the path
// that sets the clock is the Content-Length multiply-by-ten, add and cap compare.
// A new byte is taken every cycle while the output stage is empty or being drained,
// so the sustained rate is one item per cycle. A stalled output holds its item and
// blocks the s side only while it stays full. Reset (synchronous, active low)
// clears all parser state to the method phase and sets max_body_bytes to 65535.
module http_request_byte_parser_top import hrbp_pkg::*; #(
    parameter int LENGTH_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_in
    input  logic        i_s_tuser,   // [0] start_req
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] byte_out, [8] field_end, [12:9] method_code, [13] method_valid,
    // [14] header_done, [38:15] content_length, [39] length_flag
    output logic [39:0] o_m_tdata,
    output logic [2:0]  o_m_tuser,   // [2:0] byte_kind
    output logic        o_m_tlast,   // request_done
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data   // max_body_bytes
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX   = '1;
    localparam logic [23:0]            MAX_RESET = 24'd65535;

    // parser state
    t_ctl                   r_ctl;
    logic [LENGTH_BITS-1:0] r_value_accum;
    logic [LENGTH_BITS-1:0] r_length_value;
    logic [LENGTH_BITS-1:0] r_body_count;
    logic [23:0]            r_max_body;

    t_ctl                   n_ctl;
    logic [LENGTH_BITS-1:0] n_value_accum;
    logic [LENGTH_BITS-1:0] n_length_value;
    logic [LENGTH_BITS-1:0] n_body_count;
    t_result                n_res;

    // output stage
    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    t_result                r_out_res;
    logic [23:0]            r_out_length;
    logic                   r_out_flag;

    logic                   in_accept;
    logic [LENGTH_BITS-1:0] cap;

    // Accept while the output stage is empty or drains this cycle
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign in_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // Limit the register to what the length counters can hold
    assign cap = ((LENGTH_BITS < 24) && (r_max_body > 24'(LEN_MAX)))
               ? LEN_MAX : LENGTH_BITS'(r_max_body);

    hrbp_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_ctl          (r_ctl),
        .i_value_accum  (r_value_accum),
        .i_length_value (r_length_value),
        .i_body_count   (r_body_count),
        .i_cap          (cap),
        .i_byte         (i_s_tdata),
        .i_start        (i_s_tuser),
        .o_ctl          (n_ctl),
        .o_value_accum  (n_value_accum),
        .o_length_value (n_length_value),
        .o_body_count   (n_body_count),
        .o_res          (n_res)
    );

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body <= MAX_RESET;
        end else if (i_cfg_valid) begin
            r_max_body <= i_cfg_data;
        end
    end

    // Parser state: advance on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.phase        <= PH_METHOD;
            r_ctl.method_match <= '1;
            r_ctl.method_len   <= '0;
            r_ctl.name_pos     <= '0;
            r_ctl.name_matches <= 1'b1;
            r_ctl.in_value     <= 1'b0;
            r_ctl.skip_next    <= 1'b0;
            r_ctl.digits       <= DG_LEAD;
            r_ctl.value_over   <= 1'b0;
            r_ctl.length_seen  <= 1'b0;
            r_ctl.length_bad   <= 1'b0;
            r_value_accum      <= '0;
            r_length_value     <= '0;
            r_body_count       <= '0;
        end else if (in_accept) begin
            r_ctl          <= n_ctl;
            r_value_accum  <= n_value_accum;
            r_length_value <= n_length_value;
            r_body_count   <= n_body_count;
        end
    end

    // Output stage valid: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_byte   <= i_s_tdata;
            r_out_res    <= n_res;
            r_out_length <= 24'(n_length_value);
            r_out_flag   <= n_ctl.length_bad;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_flag, r_out_length, r_out_res.header_done,
                         r_out_res.method_valid, r_out_res.method_code,
                         r_out_res.field_end, r_out_byte};
    assign o_m_tuser  = r_out_res.byte_kind;
    assign o_m_tlast  = r_out_res.request_done;

`ifndef ASSERT_OFF
    // request end falls on the blank line or on the closing body byte
    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.request_done)
            |-> (r_out_res.field_end || r_out_res.header_done))
        else $error("request_done without a closing byte");

    // the method ends on a dropped space that also closes the field
    a_method_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.method_valid)
            |-> (r_out_res.field_end && (r_out_res.byte_kind == KIND_DROPPED)))
        else $error("method_valid on a kept byte");

    // a method code shows only on the method's closing byte
    a_code_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_res.method_code != 4'd0)) |-> r_out_res.method_valid)
        else $error("method_code without method_valid");

    // header end is a dropped LF
    a_header_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.header_done)
            |-> ((r_out_res.byte_kind == KIND_DROPPED) && (r_out_byte == CH_LF)))
        else $error("header_done on a byte other than LF");

    // an empty output stage never blocks the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_tready)
        else $error("input stalled with empty output stage");
`endif

endmodule
